// ===== design/swdt_pkg.sv =====
package swdt_pkg;

  localparam int unsigned KIND_W     = 3;
  localparam int unsigned KLEN_W     = 16;
  localparam int unsigned SIZE_W     = 48;
  localparam int unsigned CNT_W      = 13;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 48;

  localparam logic [KLEN_W-1:0] MIN_KEY_BYTES = KLEN_W'(4);

  typedef enum logic [KIND_W-1:0] {
    KIND_PUT           = 3'd0,
    KIND_DELETE        = 3'd1,
    KIND_SINGLE_DELETE = 3'd2,
    KIND_MERGE         = 3'd3,
    KIND_OTHER         = 3'd4
  } entry_kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_LENGTH        = 2'd0,
    REG_DELETE_THRESHOLD     = 2'd1,
    REG_SIZE_THRESHOLD       = 2'd2,
    REG_COUNT_SINGLE_DELETES = 2'd3
  } cfg_reg_e;

endpackage

// ===== design/swdt_ram.sv =====
module swdt_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 4096,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/swdt_clear.sv =====
module swdt_clear #(
  parameter int unsigned DEPTH = 4096,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  output logic          busy_o,
  output logic [AW-1:0] addr_o
);

  localparam logic [AW-1:0] LastAddr = AW'(DEPTH - 1);

  logic          busy_q, busy_d;
  logic [AW-1:0] addr_q, addr_d;

  always_comb begin
    busy_d = busy_q;
    addr_d = addr_q;
    if (busy_q) begin
      if (addr_q == LastAddr) begin
        busy_d = 1'b0;
      end else begin
        addr_d = addr_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      addr_q <= '0;
    end else begin
      busy_q <= busy_d;
      addr_q <= addr_d;
    end
  end

  assign busy_o = busy_q;
  assign addr_o = addr_q;

endmodule

// ===== design/sliding_window_delete_tracker_unit.sv =====
// Sliding-window delete tracker. Each request carries one entry; entries with
// keys of four bytes or more write an is-delete flag into a ring held in a
// one-bit-wide RAM of WINDOW_DEPTH entries, and every request yields one
// result with the window delete count, its peak since reset and the
// compaction-needed flag. One request is taken every cycle unless the output
// stalls; a result passes the stage-one registers and then the output
// register, as the read of the flag RAM is registered (a write-to-read
// bypass covers back-to-back hits on one ring slot). After reset the flag
// RAM is swept to zero, one entry per cycle, so requests stall until the
// sweep ends; configuration writes are taken during the sweep.
module sliding_window_delete_tracker_unit
  import swdt_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH = 4096
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [KIND_W-1:0]     in_entry_kind_i,
  input  logic [KLEN_W-1:0]     in_key_length_i,
  input  logic [SIZE_W-1:0]     in_current_file_size_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  out_accepted_o,
  output logic [CNT_W-1:0]      out_window_deletes_o,
  output logic [CNT_W-1:0]      out_peak_deletes_o,
  output logic                  out_compact_needed_o
);

  localparam int unsigned PW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned CW = ((PW > CNT_W) ? PW : CNT_W) + 1;

  // Configuration registers.
  logic [CNT_W-1:0]  window_length_q;
  logic [CNT_W-1:0]  delete_threshold_q;
  logic [SIZE_W-1:0] size_threshold_q;
  logic              count_single_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_length_q    <= '0;
      delete_threshold_q <= '0;
      size_threshold_q   <= '0;
      count_single_q     <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_WINDOW_LENGTH:        window_length_q    <= cfg_data_i[CNT_W-1:0];
        REG_DELETE_THRESHOLD:     delete_threshold_q <= cfg_data_i[CNT_W-1:0];
        REG_SIZE_THRESHOLD:       size_threshold_q   <= cfg_data_i[SIZE_W-1:0];
        REG_COUNT_SINGLE_DELETES: count_single_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // The window is clamped to the depth of the flag RAM.
  logic [CW-1:0] win_ext;
  logic          track_en;

  always_comb begin
    if (CW'(window_length_q) > CW'(WINDOW_DEPTH)) begin
      win_ext = CW'(WINDOW_DEPTH);
    end else begin
      win_ext = CW'(window_length_q);
    end
  end

  assign track_en = (window_length_q != '0);

  // Clearing sweep after reset.
  logic          clr_busy;
  logic [PW-1:0] clr_addr;

  swdt_clear #(
    .DEPTH (WINDOW_DEPTH)
  ) u_clear (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .busy_o (clr_busy),
    .addr_o (clr_addr)
  );

  // Pipeline registers.
  logic              s1_valid_q;
  logic              s1_acc_q;
  logic              s1_track_q;
  logic              s1_del_q;
  logic [PW-1:0]     s1_pos_q;
  logic [SIZE_W-1:0] s1_size_q;
  logic              fwd_hit_q;
  logic              fwd_data_q;
  logic [PW-1:0]     ring_q, ring_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  peak_q, peak_d;
  logic [SIZE_W-1:0] last_size_q, last_size_d;
  logic              out_valid_q;
  logic              out_acc_q;
  logic [CNT_W-1:0]  out_count_q;
  logic [CNT_W-1:0]  out_peak_q;
  logic              out_compact_q;

  logic              s1_go;
  logic              commit;
  logic              in_acc;
  logic              in_long;
  logic              in_track;
  logic              in_del;
  logic [PW-1:0]     in_pos;
  logic [CW-1:0]     pos_inc;
  logic              rd_flag;
  logic              old_flag;
  logic              flip;
  logic              flag_we;
  logic [CNT_W-1:0]  count_inc;
  logic              compact_d;

  assign s1_go      = !out_valid_q || !out_stall_i;
  assign commit     = s1_valid_q && s1_go;
  assign in_stall_o = clr_busy || (s1_valid_q && !s1_go);
  assign in_acc     = in_valid_i && !in_stall_o;

  assign in_long  = (in_key_length_i >= MIN_KEY_BYTES);
  assign in_track = in_long && track_en;
  assign in_del   = (in_entry_kind_i == KIND_DELETE) ||
                    ((in_entry_kind_i == KIND_SINGLE_DELETE) && count_single_q);

  // A position left beyond a shrunk window restarts at slot zero.
  always_comb begin
    if (CW'(ring_q) >= win_ext) begin
      in_pos = '0;
    end else begin
      in_pos = ring_q;
    end
    pos_inc = CW'(in_pos) + CW'(1);
    ring_d  = ring_q;
    if (in_acc && in_track) begin
      if (pos_inc >= win_ext) begin
        ring_d = '0;
      end else begin
        ring_d = pos_inc[PW-1:0];
      end
    end
  end

  // Read-modify-write of the flag at the second stage.
  assign old_flag  = fwd_hit_q ? fwd_data_q : rd_flag;
  assign flip      = s1_track_q && (old_flag != s1_del_q);
  assign flag_we   = commit && flip;
  assign count_inc = count_q + CNT_W'(1);

  always_comb begin
    count_d     = count_q;
    peak_d      = peak_q;
    last_size_d = last_size_q;
    if (commit) begin
      if (flip) begin
        if (s1_del_q) begin
          count_d = count_inc;
          if (count_inc > peak_q) begin
            peak_d = count_inc;
          end
        end else if (count_q != '0) begin
          count_d = count_q - CNT_W'(1);
        end
      end
      if (s1_acc_q) begin
        last_size_d = s1_size_q;
      end
    end
  end

  assign compact_d = (delete_threshold_q != '0) && track_en &&
                     (last_size_d > size_threshold_q) &&
                     (peak_d > delete_threshold_q);

  swdt_ram #(
    .WIDTH (1),
    .DEPTH (WINDOW_DEPTH)
  ) u_flags (
    .clk_i   (clk_i),
    .we_i    (clr_busy || flag_we),
    .waddr_i (clr_busy ? clr_addr : s1_pos_q),
    .wdata_i (clr_busy ? 1'b0 : s1_del_q),
    .re_i    (in_acc && in_track),
    .raddr_i (in_pos),
    .rdata_o (rd_flag)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      ring_q      <= '0;
      count_q     <= '0;
      peak_q      <= '0;
      last_size_q <= '0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_go) begin
        s1_valid_q <= 1'b0;
      end
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      ring_q      <= ring_d;
      count_q     <= count_d;
      peak_q      <= peak_d;
      last_size_q <= last_size_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_acc_q   <= in_long;
      s1_track_q <= in_track;
      s1_del_q   <= in_del;
      s1_pos_q   <= in_pos;
      s1_size_q  <= in_current_file_size_i;
      // The RAM returns the old flag when the slot is written in the read cycle.
      fwd_hit_q  <= flag_we && (s1_pos_q == in_pos);
      fwd_data_q <= s1_del_q;
    end
    if (commit) begin
      out_acc_q     <= s1_acc_q;
      out_count_q   <= count_d;
      out_peak_q    <= peak_d;
      out_compact_q <= compact_d;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign out_accepted_o       = out_acc_q;
  assign out_window_deletes_o = out_count_q;
  assign out_peak_deletes_o   = out_peak_q;
  assign out_compact_needed_o = out_compact_q;

endmodule
